@@ rtl/psq_pkg.sv @@
// Package for the polyline stroke quad expander: widths, sequencer states,
// configuration register indexes and a saturating helper. No dependencies.
`default_nettype none
package psq_pkg;
  localparam int CW = 24;
  localparam int FB = 8;
  localparam int RW = 16;
  localparam int DW = CW + 1;     // segment delta width
  localparam int SQW = 2 * DW + 1; // sum of squares width
  localparam int LW = DW + 1;      // root width
  localparam int NW = DW + 2 * RW; // dividend width
  localparam int MW = DW + 1;      // multiplier operand width
  localparam int PW = 2 * MW;      // multiplier product width

  localparam logic [1:0] REG_SCALE_X = 2'd0;
  localparam logic [1:0] REG_SCALE_Y = 2'd1;
  localparam logic [1:0] REG_STROKE = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SX1, ST_SY1, ST_SX2, ST_SY2, ST_TX, ST_TY, ST_SQX, ST_SQY,
    ST_ROOT, ST_PX, ST_DIVX, ST_PY, ST_DIVY, ST_OUT
  } state_t;

  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  function automatic logic signed [CW-1:0] sat(input logic signed [CW+RW+1:0] v);
    if (v > $signed({{(RW+2){1'b0}}, CMAX})) return CMAX;
    if (v < $signed({{(RW+2){1'b1}}, CMIN})) return CMIN;
    return v[CW-1:0];
  endfunction
endpackage
`default_nettype wire

@@ rtl/psq_mul.sv @@
// Shared registered multiplier used by the sequencer for every product.
// Depends on psq_pkg.
`default_nettype none
module psq_mul import psq_pkg::*; (
  input  wire logic clk,
  input  wire logic signed [MW-1:0] a,
  input  wire logic signed [MW-1:0] b,
  output logic signed [PW-1:0] p
);
  always_ff @(posedge clk) begin
    p <= a * b;
  end
endmodule
`default_nettype wire

@@ rtl/psq_sqrt.sv @@
// Bit-pair iterative integer square root, one bit of root per cycle.
// Depends on psq_pkg.
`default_nettype none
module psq_sqrt import psq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic [SQW-1:0] n,
  output logic busy,
  output logic [LW-1:0] root
);
  logic [SQW+1:0] rem;
  logic [SQW+1:0] res;
  logic [SQW+1:0] bitv;
  logic [SQW+1:0] trial;
  assign trial = res + bitv;
  assign root = res[LW-1:0];
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      rem <= {2'b0, n};
      res <= '0;
      bitv <= {2'b01, {(SQW){1'b0}}} >> (SQW[0] ? 1 : 2);
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
      if (bitv[1:0] != 2'b00) busy <= 1'b0;
    end
  end
endmodule
`default_nettype wire

@@ rtl/psq_div.sv @@
// Restoring divider, one quotient bit per cycle. Depends on psq_pkg.
`default_nettype none
module psq_div import psq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic [NW-1:0] num,
  input  wire logic [LW-1:0] den,
  output logic busy,
  output logic [NW-1:0] quo
);
  logic [LW:0] rem;
  logic [LW:0] shifted;
  logic [$clog2(NW+1)-1:0] cnt;
  assign shifted = {rem[LW-1:0], quo[NW-1]};
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      quo <= num;
      rem <= '0;
      cnt <= '0;
    end else if (busy) begin
      if (shifted >= {1'b0, den}) begin
        rem <= shifted - {1'b0, den};
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[NW-2:0], 1'b0};
      end
      cnt <= cnt + 1'b1;
      if (cnt == ($clog2(NW+1))'(NW - 1)) busy <= 1'b0;
    end
  end
endmodule
`default_nettype wire

@@ rtl/psq_ctrl.sv @@
// Sequencer: stores the previous point, runs the multiplier, square root and
// divider in turn, and forms the saturated corners. Depends on psq_pkg.
`default_nettype none
module psq_ctrl import psq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [RW-1:0] cfg_data,
  input  wire logic in_fire,
  input  wire logic signed [CW-1:0] px,
  input  wire logic signed [CW-1:0] py,
  input  wire logic fresh,
  output logic idle,
  output logic res_valid,
  output logic [8*CW:0] res_data,
  input  wire logic res_taken,
  output logic signed [MW-1:0] mul_a,
  output logic signed [MW-1:0] mul_b,
  input  wire logic signed [PW-1:0] mul_p,
  output logic sq_start,
  output logic [SQW-1:0] sq_n,
  input  wire logic sq_busy,
  input  wire logic [LW-1:0] sq_root,
  output logic dv_start,
  output logic [NW-1:0] dv_num,
  output logic [LW-1:0] dv_den,
  input  wire logic dv_busy,
  input  wire logic [NW-1:0] dv_quo
);
  state_t state, state_next;
  logic [RW-1:0] scale_x, scale_y, stroke;
  logic signed [CW-1:0] prev_x, prev_y, cx, cy;
  logic have_prev;
  logic signed [CW-1:0] x1, y1, x2, y2;
  logic [CW-1:0] tx, ty;
  logic [SQW-1:0] acc;
  logic [LW-1:0] l;
  logic signed [CW+RW+1:0] nx, ny;
  logic wait_q;
  logic signed [DW-1:0] dx, dy;
  logic [DW-1:0] ax, ay;
  logic degen;
  logic signed [CW+RW+1:0] fl;

  assign dx = DW'(x2) - DW'(x1);
  assign dy = DW'(y2) - DW'(y1);
  assign ax = dx[DW-1] ? DW'(-dx) : dx;
  assign ay = dy[DW-1] ? DW'(-dy) : dy;
  assign degen = (dx == '0) && (dy == '0);
  assign fl = (CW+RW+2)'(mul_p >>> FB);
  assign idle = (state == ST_IDLE) && !res_valid;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_fire && !fresh && have_prev) state_next = ST_SX1;
      ST_SX1:  state_next = ST_SY1;
      ST_SY1:  state_next = ST_SX2;
      ST_SX2:  state_next = ST_SY2;
      ST_SY2:  state_next = ST_TX;
      ST_TX:   state_next = ST_TY;
      ST_TY:   state_next = degen ? ST_OUT : ST_SQX;
      ST_SQX:  state_next = ST_SQY;
      ST_SQY:  state_next = ST_ROOT;
      ST_ROOT: if (wait_q && !sq_busy) state_next = ST_PX;
      ST_PX:   state_next = ST_DIVX;
      ST_DIVX: if (wait_q && !dv_busy) state_next = ST_PY;
      ST_PY:   state_next = ST_DIVY;
      ST_DIVY: if (wait_q && !dv_busy) state_next = ST_OUT;
      ST_OUT:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // multiplier operand select; the product lands in the next cycle
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_IDLE: begin mul_a = MW'(prev_x); mul_b = MW'({1'b0, scale_x}); end
      ST_SX1:  begin mul_a = MW'(y1);     mul_b = MW'({1'b0, scale_y}); end
      ST_SY1:  begin mul_a = MW'(cx);     mul_b = MW'({1'b0, scale_x}); end
      ST_SX2:  begin mul_a = MW'(cy);     mul_b = MW'({1'b0, scale_y}); end
      ST_SY2:  begin mul_a = MW'({1'b0, stroke}); mul_b = MW'({1'b0, scale_x}); end
      ST_TX:   begin mul_a = MW'({1'b0, stroke}); mul_b = MW'({1'b0, scale_y}); end
      ST_TY:   begin mul_a = {1'b0, ax}; mul_b = {1'b0, ax}; end
      ST_SQX:  begin mul_a = {1'b0, ay}; mul_b = {1'b0, ay}; end
      // held so the product is ready when the divide starts
      ST_ROOT: begin mul_a = {1'b0, ay}; mul_b = MW'(tx); end
      ST_PX, ST_DIVX: begin mul_a = {1'b0, ax}; mul_b = MW'(ty); end
      default: ;
    endcase
  end

  assign sq_start = (state == ST_SQY);
  assign sq_n = acc + SQW'(mul_p);
  assign dv_start = (state == ST_PX) || (state == ST_PY);
  assign dv_num = NW'(mul_p) + NW'(l >> 1);
  assign dv_den = l;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      scale_x <= RW'(256);
      scale_y <= RW'(256);
      stroke <= RW'(256);
      prev_x <= '0;
      prev_y <= '0;
      have_prev <= 1'b0;
      res_valid <= 1'b0;
      wait_q <= 1'b0;
    end else begin
      state <= state_next;
      wait_q <= (state == ST_ROOT || state == ST_DIVX || state == ST_DIVY)
                && state_next == state;
      if (cfg_we) begin
        case (cfg_index)
          REG_SCALE_X: scale_x <= cfg_data;
          REG_SCALE_Y: scale_y <= cfg_data;
          REG_STROKE:  stroke <= cfg_data;
          default: ;
        endcase
      end
      if (in_fire) begin
        cx <= px;
        cy <= py;
        prev_x <= px;
        prev_y <= py;
        have_prev <= 1'b1;
      end
      if (res_taken) res_valid <= 1'b0;
      if (state == ST_OUT) res_valid <= 1'b1;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_fire) begin
      y1 <= prev_y; // hold old y for its product
    end
    case (state)
      ST_SX1:  x1 <= sat(fl);
      ST_SY1:  y1 <= sat(fl);
      ST_SX2:  x2 <= sat(fl);
      ST_SY2:  y2 <= sat(fl);
      ST_TX:   tx <= CW'(mul_p >>> (FB + 1));
      ST_TY:   begin ty <= CW'(mul_p >>> (FB + 1)); nx <= '0; ny <= '0; end
      ST_SQX:  acc <= SQW'(mul_p);
      default: ;
    endcase
    if (state == ST_ROOT && wait_q && !sq_busy) l <= (sq_root == '0) ? LW'(1) : sq_root;
    if (state == ST_DIVX && wait_q && !dv_busy)
      nx <= dy[DW-1] || dy == '0 ? (CW+RW+2)'(dv_quo) : -(CW+RW+2)'(dv_quo);
    if (state == ST_DIVY && wait_q && !dv_busy)
      ny <= dx[DW-1] ? -(CW+RW+2)'(dv_quo) : (CW+RW+2)'(dv_quo);
    if (state == ST_OUT) begin
      res_data <= {degen,
        sat((CW+RW+2)'(y2) - ny), sat((CW+RW+2)'(x2) - nx),
        sat((CW+RW+2)'(y2) + ny), sat((CW+RW+2)'(x2) + nx),
        sat((CW+RW+2)'(y1) - ny), sat((CW+RW+2)'(x1) - nx),
        sat((CW+RW+2)'(y1) + ny), sat((CW+RW+2)'(x1) + nx)};
    end
  end
endmodule
`default_nettype wire

@@ rtl/polyline_stroke_quad_expand_core.sv @@
// Top level of the polyline stroke quad expander: handshakes and unit wiring.
// Depends on psq_pkg, psq_mul, psq_sqrt, psq_div, psq_ctrl.
//
//  channel  | direction | payload
//  s_axis   | in        | tdata: point_x, point_y; tuser: new_stroke
//  m_axis   | out       | tdata: 8 corners; tuser: degenerate
//  cfg      | in        | cfg_we, cfg_index, cfg_data
//
// After a segment's end point is accepted, the shared multiplier scales both
// points and the pen width and squares the deltas; the square root follows
// (one root bit a cycle), then two restoring divides (one quotient bit a
// cycle). A zero-length segment skips the squares, root and divides. A point
// that only starts a stroke gives no result. rst is synchronous.
// Input is not ready while a segment is in work or a result waits.
`default_nettype none
module polyline_stroke_quad_expand_core import psq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [RW-1:0] cfg_data,
  input  wire logic s_axis_tvalid,
  output logic s_axis_tready,
  input  wire logic [2*CW-1:0] s_axis_tdata, // point_x, point_y
  input  wire logic s_axis_tuser,            // new_stroke
  output logic m_axis_tvalid,
  input  wire logic m_axis_tready,
  output logic [8*CW-1:0] m_axis_tdata,      // sl_x, sl_y, sr_x, sr_y, el_x, el_y, er_x, er_y
  output logic m_axis_tuser                  // degenerate
);
  logic idle, in_fire;
  logic [8*CW:0] res_data;
  logic signed [MW-1:0] mul_a;
  logic signed [MW-1:0] mul_b;
  logic signed [PW-1:0] mul_p;
  logic sq_start, sq_busy, dv_start, dv_busy;
  logic [SQW-1:0] sq_n;
  logic [LW-1:0] sq_root, dv_den;
  logic [NW-1:0] dv_num, dv_quo;

  assign s_axis_tready = idle;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata = res_data[8*CW-1:0];
  assign m_axis_tuser = res_data[8*CW];

  psq_mul u_mul (.clk, .a(mul_a), .b(mul_b), .p(mul_p));
  psq_sqrt u_sqrt (.clk, .rst, .start(sq_start), .n(sq_n), .busy(sq_busy), .root(sq_root));
  psq_div u_div (.clk, .rst, .start(dv_start), .num(dv_num), .den(dv_den),
    .busy(dv_busy), .quo(dv_quo));
  psq_ctrl u_ctrl (.clk, .rst, .cfg_we, .cfg_index, .cfg_data, .in_fire,
    .px(s_axis_tdata[CW-1:0]), .py(s_axis_tdata[2*CW-1:CW]), .fresh(s_axis_tuser),
    .idle, .res_valid(m_axis_tvalid), .res_data,
    .res_taken(m_axis_tvalid && m_axis_tready),
    .mul_a, .mul_b, .mul_p, .sq_start, .sq_n, .sq_busy, .sq_root,
    .dv_start, .dv_num, .dv_den, .dv_busy, .dv_quo);
endmodule
`default_nettype wire

@@ bench/polyline_stroke_quad_expand_core_tb.sv @@
// Testbench for polyline_stroke_quad_expand_core: random and directed pen points,
// a scoreboard with a built-in quad predictor. Depends on psq_pkg and the core.
`default_nettype none
module polyline_stroke_quad_expand_core_tb import psq_pkg::*;;

  typedef struct {
    logic [8*CW-1:0] corners;
    logic degen;
  } quad_t;

  class quad_scoreboard;
    logic [15:0] sc_x = 16'd256, sc_y = 16'd256, pen = 16'd256;
    longint last_x = 0, last_y = 0;
    bit started = 0;
    quad_t pending[$];
    int errors = 0;

    function longint sx24(logic [CW-1:0] v);
      return longint'($signed(v));
    endfunction

    function longint clampc(longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
    endfunction

    // arithmetic shift is a floor for negatives
    function longint scale_pt(longint p, logic [15:0] s);
      return clampc((p * longint'({1'b0, s})) >>> FB);
    endfunction

    function longint unsigned root(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n -= res + b;
          res = (res >> 1) + b;
        end else res >>= 1;
        b >>= 2;
      end
      return res;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] v);
      if (idx == REG_SCALE_X) sc_x = v;
      else if (idx == REG_SCALE_Y) sc_y = v;
      else if (idx == REG_STROKE) pen = v;
    endfunction

    function void note_point(logic [CW-1:0] px_raw, logic [CW-1:0] py_raw, bit fresh);
      longint px, py, x1, y1, x2, y2, dx, dy, nx, ny;
      longint unsigned ax, ay, tx, ty, l, mx, my;
      quad_t q;
      px = sx24(px_raw);
      py = sx24(py_raw);
      if (fresh || !started) begin
        last_x = px; last_y = py; started = 1;
        return;
      end
      x1 = scale_pt(last_x, sc_x);
      y1 = scale_pt(last_y, sc_y);
      x2 = scale_pt(px, sc_x);
      y2 = scale_pt(py, sc_y);
      last_x = px; last_y = py;
      tx = (longint'(pen) * longint'(sc_x)) >> (FB + 1);
      ty = (longint'(pen) * longint'(sc_y)) >> (FB + 1);
      dx = x2 - x1;
      dy = y2 - y1;
      nx = 0; ny = 0;
      q.degen = (dx == 0 && dy == 0);
      if (!q.degen) begin
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        while (ax >= (64'd1 << 31) || ay >= (64'd1 << 31)) begin
          ax >>= 1; ay >>= 1;
        end
        l = root(ax * ax + ay * ay);
        if (l == 0) l = 1;
        mx = (ay * tx + (l >> 1)) / l;
        my = (ax * ty + (l >> 1)) / l;
        nx = dy > 0 ? -longint'(mx) : longint'(mx);
        ny = dx < 0 ? -longint'(my) : longint'(my);
      end
      q.corners = {CW'(clampc(y2 - ny)), CW'(clampc(x2 - nx)),
                   CW'(clampc(y2 + ny)), CW'(clampc(x2 + nx)),
                   CW'(clampc(y1 - ny)), CW'(clampc(x1 - nx)),
                   CW'(clampc(y1 + ny)), CW'(clampc(x1 + nx))};
      pending.push_back(q);
    endfunction

    task report(string what);
      $display("ERROR %0t: %s", $time, what);
      errors++;
    endtask

    task check_quad(logic [8*CW-1:0] got, logic got_degen);
      quad_t q;
      if (pending.size() == 0) begin
        report("quad with no segment pending");
        return;
      end
      q = pending.pop_front();
      for (int k = 0; k < 8; k++)
        if (got[k*CW +: CW] !== q.corners[k*CW +: CW])
          report($sformatf("corner %0d got %h want %h", k, got[k*CW +: CW],
                           q.corners[k*CW +: CW]));
      if (got_degen !== q.degen)
        report($sformatf("degenerate got %b want %b", got_degen, q.degen));
    endtask
  endclass

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [RW-1:0] cfg_data = '0;
  logic s_axis_tvalid = 0, s_axis_tready;
  logic [2*CW-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 0;
  logic m_axis_tvalid, m_axis_tready = 0;
  logic [8*CW-1:0] m_axis_tdata;
  logic m_axis_tuser;
  bit quiet = 0;
  quad_scoreboard sb = new();

  always #2 clk = ~clk;

  polyline_stroke_quad_expand_core u_top (.*);

  // result side: random stall bursts, checks each accepted quad
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) sb.check_quad(m_axis_tdata, m_axis_tuser);
      if (stall > 0) stall--;
      else if (!quiet && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 3);
      m_axis_tready <= (stall == 0) && !rst;
    end
  end

  // valid stays up after an accept until the next item or an idle stretch
  task send_point(logic [CW-1:0] px, logic [CW-1:0] py, bit fresh);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {py, px};
    s_axis_tuser <= fresh;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_point(px, py, fresh);
  endtask

  task drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task write_cfg(logic [1:0] idx, logic [15:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
    cfg_we <= 0;
  endtask

  function logic [CW-1:0] rnd_coord();
    case ($urandom_range(0, 3))
      0: return CW'($urandom);
      1: return CW'($urandom_range(0, 4095) - 2048);
      2: return $urandom_range(0, 1) ? CW'(24'h7FFFFF - $urandom_range(0, 255))
                                     : CW'(24'h800000 + $urandom_range(0, 255));
      default: return CW'($urandom_range(0, 65535) - 32768);
    endcase
  endfunction

  task random_phase(int n);
    for (int i = 0; i < n; i++)
      send_point(rnd_coord(), rnd_coord(), $urandom_range(0, 7) == 0);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: extremes, zero length, stroke restarts
    send_point(24'h000000, 24'h000000, 0);
    send_point(24'h000000, 24'h000000, 0);
    send_point(24'h7FFFFF, 24'h7FFFFF, 0);
    send_point(24'h800000, 24'h800000, 0);
    send_point(24'h7FFFFF, 24'h800000, 0);
    send_point(24'h000100, 24'h000100, 1);
    send_point(24'h000200, 24'h000100, 0);
    send_point(24'h000200, 24'h000300, 0);
    send_point(24'hFFFF00, 24'h000300, 0);
    send_point(24'hFFFF00, 24'hFFFE00, 0);
    send_point(24'hFFFF00, 24'hFFFE00, 0);
    send_point(24'hAAAAAA, 24'h555555, 0);
    send_point(24'h555555, 24'hAAAAAA, 0);
    drain();
    write_cfg(REG_SCALE_X, 16'hFFFF);
    write_cfg(REG_SCALE_Y, 16'hFFFF);
    write_cfg(REG_STROKE, 16'hFFFF);
    write_cfg(2'd3, 16'h1234);
    send_point(24'h7FFFFF, 24'h000000, 1);
    send_point(24'h800000, 24'h000001, 0);
    send_point(24'h000001, 24'h000001, 0);
    send_point(24'h000002, 24'h000003, 0);
    random_phase(250);
    drain();
    write_cfg(REG_SCALE_X, 16'h0000);
    write_cfg(REG_SCALE_Y, 16'h0080);
    write_cfg(REG_STROKE, 16'h0000);
    send_point(24'h001000, 24'h001000, 0);
    send_point(24'h002000, 24'h001000, 0);
    random_phase(250);
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_cfg(REG_SCALE_X, 16'($urandom));
      write_cfg(REG_SCALE_Y, 16'($urandom));
      write_cfg(REG_STROKE, 16'($urandom));
      random_phase(250);
    end
    drain();
    write_cfg(REG_SCALE_X, 16'd256);
    write_cfg(REG_SCALE_Y, 16'd256);
    write_cfg(REG_STROKE, 16'd256);
    quiet = 1;
    random_phase(100);
    drain();
    if (sb.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #10000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
